// ===== hdl/vib_pkg.sv =====
// ----------------------------------------------------------------------------
// vib_pkg
// Shared types, constants and field arithmetic for the Vandermonde inverse
// builder.
// ----------------------------------------------------------------------------
package vib_pkg;

  localparam int unsigned N      = 16;
  localparam int unsigned NW     = $clog2(N);
  localparam int unsigned CW     = NW + 1;
  localparam int unsigned PE     = 31;
  localparam int unsigned NR     = 256;
  localparam int unsigned NRW    = $clog2(NR);
  localparam int unsigned MW     = 2 * NW;
  localparam logic [PE-1:0] PVAL = {PE{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_LOAD = 2'd1,
    FUNC_EVAL = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_DEN_RD,
    ST_DEN_MUL,
    ST_COL_RD,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_HERE_WR,
    ST_KDEN_WR,
    ST_EV_RD,
    ST_EV_M1,
    ST_EV_M2,
    ST_EV_ACC,
    ST_DONE
  } state_e;

  typedef logic [PE-1:0] fe_t;

  function automatic fe_t fold(input logic [2*PE-1:0] v);
    logic [PE:0] s;
    begin
      s = {1'b0, v[PE-1:0]} + {1'b0, v[2*PE-1:PE]};
      s = {1'b0, s[PE-1:0]} + {{PE{1'b0}}, s[PE]};
      fold = (s[PE-1:0] == PVAL) ? '0 : s[PE-1:0];
    end
  endfunction

  function automatic fe_t fsub(input fe_t a, input fe_t b);
    logic [PE:0] s;
    begin
      s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, PVAL} - {1'b0, b};
      fsub = s[PE-1:0];
    end
  endfunction

  function automatic fe_t fadd(input fe_t a, input fe_t b);
    logic [PE:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      fadd = (s >= {1'b0, PVAL}) ? fe_t'(s - {1'b0, PVAL}) : s[PE-1:0];
    end
  endfunction

  function automatic fe_t fneg(input fe_t a);
    fneg = (a == '0) ? '0 : PVAL - a;
  endfunction

  // square-and-multiply inverse, evaluated at elaboration for the table
  function automatic fe_t finv(input int unsigned a);
    fe_t r;
    fe_t b;
    logic [PE-1:0] e;
    begin
      r = fe_t'(1);
      b = fold({{PE{1'b0}}, PE'(a)});
      e = PVAL - fe_t'(2);
      if (b == '0) r = '0;
      else begin
        for (int i = 0; i < PE; i++) begin
          if (e[i]) r = fold({{PE{1'b0}}, r} * {{PE{1'b0}}, b});
          b = fold({{PE{1'b0}}, b} * {{PE{1'b0}}, b});
        end
      end
      finv = r;
    end
  endfunction

  function automatic fe_t inv_lut(input logic [NRW-1:0] d);
    fe_t t [NR];
    begin
      for (int i = 0; i < NR; i++) t[i] = finv(i);
      inv_lut = t[d];
    end
  endfunction

endpackage

// ===== hdl/vib_ram.sv =====
// ----------------------------------------------------------------------------
// vib_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vib_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/vib_mul.sv =====
// ----------------------------------------------------------------------------
// vib_mul
// Registered modular multiplier over the Mersenne prime field.
// ----------------------------------------------------------------------------
module vib_mul (
  input  logic           clk_i,
  input  vib_pkg::fe_t   a_i,
  input  vib_pkg::fe_t   b_i,
  output vib_pkg::fe_t   p_o
);

  logic [2*vib_pkg::PE-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {{vib_pkg::PE{1'b0}}, a_i} * {{vib_pkg::PE{1'b0}}, b_i};
  end

  assign p_o = vib_pkg::fold(prod_q);

endmodule

// ===== hdl/vandermonde_inverse_builder.sv =====
// ----------------------------------------------------------------------------
// vandermonde_inverse_builder
// One request at a time; busy is high while working. After reset a clearing
// pass over the numerator RAM runs with busy high.
// Results show on a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vandermonde_inverse_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [7:0]  node_value_i,
  input  logic [30:0] data_value_i,
  input  logic [3:0]  position_i,
  output logic        done,
  output logic [4:0]  progress_o,
  output logic [30:0] coefficient_o,
  output logic        full_error_o
);

  vib_pkg::state_e state_q, state_d;
  logic [vib_pkg::MW-1:0] clr_q;
  logic [vib_pkg::CW-1:0] cnt_q;
  logic [vib_pkg::NW-1:0] j_q, pos_q;
  logic [vib_pkg::CW-1:0] i_q;
  logic [7:0]      node_q;
  vib_pkg::fe_t    below_q, hn_q, acc_q, ne_q, dk_q, iv;
  logic            gt_q;
  logic [1:0]      func_q;

  logic [7:0]      nodes_q [vib_pkg::N];
  vib_pkg::fe_t    den_q   [vib_pkg::N];

  // numerator RAM
  logic            nm_we;
  logic [vib_pkg::MW-1:0] nm_wa, nm_ra;
  vib_pkg::fe_t    nm_wd, nm_rd;
  // data RAM
  logic            dt_we;
  vib_pkg::fe_t    dt_rd;
  logic [vib_pkg::NW-1:0] dt_ra;

  vib_pkg::fe_t    ma, mb, mp;

  vib_ram #(.WIDTH(vib_pkg::PE), .DEPTH(vib_pkg::N * vib_pkg::N)) u_num (
    .clk_i, .we_i(nm_we), .waddr_i(nm_wa), .wdata_i(nm_wd),
    .raddr_i(nm_ra), .rdata_o(nm_rd)
  );

  vib_ram #(.WIDTH(vib_pkg::PE), .DEPTH(vib_pkg::N)) u_dat (
    .clk_i, .we_i(dt_we), .waddr_i(position_i[vib_pkg::NW-1:0]),
    .wdata_i(vib_pkg::fold({31'd0, data_value_i})),
    .raddr_i(dt_ra), .rdata_o(dt_rd)
  );

  vib_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  logic [vib_pkg::NW-1:0] k;
  logic [7:0]    diff;
  logic          accept;
  vib_pkg::fe_t  here_new;
  assign k      = cnt_q[vib_pkg::NW-1:0];
  assign accept = start && !busy;
  assign busy   = (state_q != vib_pkg::ST_IDLE);
  assign diff   = gt_q ? nodes_q[j_q] - node_q : node_q - nodes_q[j_q];
  assign dt_we  = accept && vib_pkg::func_e'(func_i) == vib_pkg::FUNC_LOAD;
  assign dt_ra  = j_q;
  assign here_new = vib_pkg::fsub(nm_rd, below_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vib_pkg::ST_CLR:     if (&clr_q) state_d = vib_pkg::ST_IDLE;
      vib_pkg::ST_IDLE: begin
        if (accept) begin
          if (vib_pkg::func_e'(func_i) == vib_pkg::FUNC_ADD && !cnt_q[vib_pkg::NW])
            state_d = vib_pkg::ST_DEN_RD;
          else if (vib_pkg::func_e'(func_i) == vib_pkg::FUNC_EVAL)
            state_d = vib_pkg::ST_EV_RD;
          else state_d = vib_pkg::ST_DONE;
        end
      end
      vib_pkg::ST_DEN_RD: begin
        if (j_q < k) state_d = vib_pkg::ST_DEN_MUL;
        else if (j_q == k) state_d = (&j_q) ? vib_pkg::ST_KDEN_WR : vib_pkg::ST_DEN_RD;
        else state_d = vib_pkg::ST_COL_RD;
      end
      vib_pkg::ST_DEN_MUL: state_d = vib_pkg::ST_COL_RD;
      vib_pkg::ST_COL_RD:  state_d = vib_pkg::ST_ROW_RD;
      vib_pkg::ST_ROW_RD:  state_d = vib_pkg::ST_ROW_WR;
      vib_pkg::ST_ROW_WR:  state_d = vib_pkg::ST_HERE_WR;
      vib_pkg::ST_HERE_WR: begin
        if (i_q == vib_pkg::CW'(1)) begin
          if (&j_q) state_d = vib_pkg::ST_KDEN_WR;
          else state_d = vib_pkg::ST_DEN_RD;
        end else state_d = vib_pkg::ST_ROW_RD;
      end
      vib_pkg::ST_KDEN_WR: state_d = vib_pkg::ST_DONE;
      vib_pkg::ST_EV_RD:   state_d = vib_pkg::ST_EV_M1;
      vib_pkg::ST_EV_M1:   state_d = vib_pkg::ST_EV_M2;
      vib_pkg::ST_EV_M2:   state_d = vib_pkg::ST_EV_ACC;
      vib_pkg::ST_EV_ACC:  state_d = (&j_q) ? vib_pkg::ST_DONE : vib_pkg::ST_EV_RD;
      vib_pkg::ST_DONE:    state_d = vib_pkg::ST_IDLE;
      default:             state_d = vib_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    nm_we = 1'b0;
    nm_wa = {i_q[vib_pkg::NW-1:0], j_q};
    nm_wd = '0;
    nm_ra = {i_q[vib_pkg::NW-1:0], j_q};
    ma    = den_q[j_q];
    mb    = iv;
    unique case (state_q)
      vib_pkg::ST_CLR: begin
        nm_we = 1'b1;
        nm_wa = clr_q;
        nm_wd = (clr_q[vib_pkg::MW-1:vib_pkg::NW] == '0) ? vib_pkg::fe_t'(1) : '0;
      end
      vib_pkg::ST_DEN_MUL: begin
        ma = den_q[j_q];
        mb = gt_q ? vib_pkg::fneg(iv) : iv;
      end
      vib_pkg::ST_COL_RD: begin
        nm_ra = {i_q[vib_pkg::NW-1:0] - vib_pkg::NW'(1), j_q};
        ma    = dk_q;
        mb    = gt_q ? iv : vib_pkg::fneg(iv);
      end
      vib_pkg::ST_ROW_RD: begin
        ma = nm_rd;
        mb = ne_q;
        nm_ra = {i_q[vib_pkg::NW-1:0], j_q};
      end
      vib_pkg::ST_ROW_WR: begin
        nm_we = 1'b1;
        nm_wa = {i_q[vib_pkg::NW-1:0] - vib_pkg::NW'(1), j_q};
        nm_wd = mp;
      end
      vib_pkg::ST_HERE_WR: begin
        nm_we = !i_q[vib_pkg::NW];
        nm_wa = {i_q[vib_pkg::NW-1:0], j_q};
        nm_wd = hn_q;
        nm_ra = {i_q[vib_pkg::NW-1:0] - vib_pkg::NW'(2), j_q};
      end
      vib_pkg::ST_EV_RD:  nm_ra = {pos_q, j_q};
      vib_pkg::ST_EV_M1: begin
        ma = nm_rd;
        mb = den_q[j_q];
      end
      vib_pkg::ST_EV_M2: begin
        ma = mp;
        mb = dt_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vib_pkg::ST_CLR;
      clr_q        <= '0;
      cnt_q        <= '0;
      done         <= 1'b0;
      func_q       <= vib_pkg::FUNC_NONE;
      node_q       <= '0;
      pos_q        <= '0;
      j_q          <= '0;
      i_q          <= '0;
      acc_q        <= '0;
      ne_q         <= '0;
      dk_q         <= '0;
      below_q      <= '0;
      hn_q         <= '0;
      gt_q         <= 1'b0;
      full_error_o <= 1'b0;
      for (int n = 0; n < vib_pkg::N; n++) begin
        nodes_q[n] <= '0;
        den_q[n]   <= vib_pkg::fe_t'(1);
      end
    end else begin
      state_q <= state_d;
      done    <= (state_q == vib_pkg::ST_DONE);
      unique case (state_q)
        vib_pkg::ST_CLR: clr_q <= clr_q + vib_pkg::MW'(1);
        vib_pkg::ST_IDLE: begin
          func_q <= func_i;
          node_q <= node_value_i;
          pos_q  <= position_i;
          j_q    <= '0;
          acc_q  <= '0;
          full_error_o <= 1'b0;
          if (accept && vib_pkg::func_e'(func_i) == vib_pkg::FUNC_ADD) begin
            full_error_o <= cnt_q[vib_pkg::NW];
            ne_q <= vib_pkg::fe_t'(node_value_i);
            dk_q <= den_q[k];
            if (!cnt_q[vib_pkg::NW]) nodes_q[k] <= node_value_i;
          end
        end
        vib_pkg::ST_DEN_RD: begin
          gt_q <= nodes_q[j_q] > node_q;
          i_q  <= cnt_q + vib_pkg::CW'(1);
          if (j_q == k) j_q <= j_q + vib_pkg::NW'(1);
        end
        vib_pkg::ST_DEN_MUL: ;
        vib_pkg::ST_COL_RD: begin
          if (j_q < k) begin
            den_q[j_q] <= mp;
          end
        end
        vib_pkg::ST_ROW_RD: begin
          below_q <= nm_rd;
          if (j_q < k && i_q == cnt_q + vib_pkg::CW'(1)) dk_q <= mp;
        end
        vib_pkg::ST_ROW_WR: hn_q <= here_new;
        vib_pkg::ST_HERE_WR: begin
          i_q <= i_q - vib_pkg::CW'(1);
          if (i_q == vib_pkg::CW'(1)) j_q <= j_q + vib_pkg::NW'(1);
        end
        vib_pkg::ST_EV_ACC: begin
          acc_q <= vib_pkg::fadd(acc_q, mp);
          j_q   <= j_q + vib_pkg::NW'(1);
        end
        vib_pkg::ST_KDEN_WR: begin
          den_q[k] <= dk_q;
          cnt_q    <= cnt_q + vib_pkg::CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb iv = vib_pkg::inv_lut(diff);

  assign progress_o    = cnt_q;
  assign coefficient_o = (vib_pkg::func_e'(func_q) == vib_pkg::FUNC_EVAL) ? acc_q : '0;

endmodule
